// ===== design/sha1_hash_engine_defines.svh =====
// assertion macros shared by the sha1 hash engine rtl
// no dependencies; included by files that carry assertions
`ifndef SHA1_HASH_ENGINE_DEFINES_SVH
`define SHA1_HASH_ENGINE_DEFINES_SVH

// same-cycle implication, clocked on clk, off during rst
`define SHA1_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, off during rst
`define SHA1_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/sha1_pkg.sv =====
// shared types, constants and round functions of the sha1 hash engine
// no dependencies; used by sha1_core and sha1_hash_engine
package sha1_pkg;

  typedef logic [4:0][31:0] digest_t;

  localparam digest_t IV = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                            32'hEFCDAB89, 32'h67452301};

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  localparam logic [31:0] PAD_MARK  = 32'h80000000;
  localparam logic [6:0]  ROUND_Q1   = 7'd20;
  localparam logic [6:0]  ROUND_Q2   = 7'd40;
  localparam logic [6:0]  ROUND_Q3   = 7'd60;
  localparam logic [6:0]  ROUND_LAST = 7'd79;
  localparam logic [6:0]  SCHED_LEN  = 7'd16;
  localparam logic [3:0]  LEN_SLOT   = 4'd14;
  localparam logic [3:0]  BLOCK_END  = 4'd15;
  localparam logic [2:0]  FULL_WORD  = 3'd4;
  localparam logic [2:0]  DIGEST_END = 3'd4;

  typedef struct packed {
    logic push;
    logic start;
    logic reinit;
  } core_ctrl_t;

  function automatic logic [31:0] round_f(input logic [6:0] t, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    if (t < ROUND_Q1)      f = (b & c) | (~b & d);
    else if (t < ROUND_Q2) f = b ^ c ^ d;
    else if (t < ROUND_Q3) f = (b & c) | (b & d) | (c & d);
    else                   f = b ^ c ^ d;
    return f;
  endfunction

  function automatic logic [31:0] round_k(input logic [6:0] t);
    logic [31:0] k;
    if (t < ROUND_Q1)      k = K0;
    else if (t < ROUND_Q2) k = K1;
    else if (t < ROUND_Q3) k = K2;
    else                   k = K3;
    return k;
  endfunction

  function automatic logic [31:0] byte_mask(input logic [2:0] cnt);
    logic [31:0] m;
    case (cnt)
      3'd0:    m = 32'h00000000;
      3'd1:    m = 32'hFF000000;
      3'd2:    m = 32'hFFFF0000;
      3'd3:    m = 32'hFFFFFF00;
      default: m = 32'hFFFFFFFF;
    endcase
    return m;
  endfunction

  function automatic logic [31:0] pad_marker(input logic [2:0] cnt);
    logic [31:0] m;
    case (cnt)
      3'd0:    m = 32'h80000000;
      3'd1:    m = 32'h00800000;
      3'd2:    m = 32'h00008000;
      3'd3:    m = 32'h00000080;
      default: m = 32'h00000000;
    endcase
    return m;
  endfunction

endpackage

// ===== design/sha1_core.sv =====
// sha1 compression: chain value, 16-word schedule shift line and one shared round unit
// depends on sha1_pkg and sha1_hash_engine_defines.svh
`include "sha1_hash_engine_defines.svh"

module sha1_core (
  input  logic                 clk,
  input  logic                 rst,
  input  sha1_pkg::core_ctrl_t ctrl,
  input  logic [31:0]          push_data,
  output logic                 done,
  output logic                 idle,
  output sha1_pkg::digest_t    digest
);

  typedef enum logic [2:0] {
    CS_IDLE  = 3'b001,
    CS_ROUND = 3'b010,
    CS_ADD   = 3'b100
  } core_state_t;

  core_state_t       state;
  logic [6:0]        round;
  sha1_pkg::digest_t chain;
  sha1_pkg::digest_t vars;
  logic [31:0]       win [16];
  logic [31:0]       w_mix;
  logic [31:0]       w_t;
  logic [31:0]       tmp;

  assign w_mix = win[13] ^ win[8] ^ win[2] ^ win[0];
  assign w_t   = (round < sha1_pkg::SCHED_LEN) ? win[0] : {w_mix[30:0], w_mix[31]};
  assign tmp   = {vars[0][26:0], vars[0][31:27]}
               + sha1_pkg::round_f(round, vars[1], vars[2], vars[3])
               + vars[4] + sha1_pkg::round_k(round) + w_t;

  assign done   = (state == CS_ADD);
  assign idle   = (state == CS_IDLE);
  assign digest = chain;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CS_IDLE;
      round <= '0;
      chain <= sha1_pkg::IV;
    end else begin
      case (state)
        CS_IDLE: begin
          if (ctrl.start) begin
            state <= CS_ROUND;
            round <= '0;
          end
          if (ctrl.reinit) begin
            chain <= sha1_pkg::IV;
          end
        end
        CS_ROUND: begin
          round <= round + 7'd1;
          if (round == sha1_pkg::ROUND_LAST) begin
            state <= CS_ADD;
          end
        end
        CS_ADD: begin
          for (int i = 0; i < 5; i++) begin
            chain[i] <= chain[i] + vars[i];
          end
          round <= '0;
          state <= CS_IDLE;
        end
        default: state <= CS_IDLE;
      endcase
    end
  end

  // working variables and schedule shift line
  always_ff @(posedge clk) begin
    if (state == CS_IDLE && ctrl.start) begin
      vars <= chain;
    end else if (state == CS_ROUND) begin
      vars[4] <= vars[3];
      vars[3] <= vars[2];
      vars[2] <= {vars[1][1:0], vars[1][31:2]};
      vars[1] <= vars[0];
      vars[0] <= tmp;
    end
    if (ctrl.push || state == CS_ROUND) begin
      for (int i = 0; i < 15; i++) begin
        win[i] <= win[i + 1];
      end
      win[15] <= ctrl.push ? push_data : w_t;
    end
  end

  `SHA1_ASSERT_IMP(a_start_idle, ctrl.start, state == CS_IDLE, "start while busy")
  `SHA1_ASSERT_IMP(a_push_idle, ctrl.push, state == CS_IDLE, "push during rounds")
  `SHA1_ASSERT_NXT(a_last_round, state == CS_ROUND && round == sha1_pkg::ROUND_LAST,
                   state == CS_ADD, "no chain add after last round")

endmodule

// ===== design/sha1_hash_engine.sv =====
// sha1 hash engine top level: input framing, padding sequencer and digest output buffer
// depends on sha1_pkg, sha1_core and sha1_hash_engine_defines.svh
//
// usage:
//   input stream (s_*): one 32-bit message word per request, first byte in bits 31:24,
//   with a count of valid leading bytes; s_tlast marks the final word. a final word
//   with count 0 closes the message without adding bytes (empty message if alone).
//   output stream (m_*): five requests per message, h0 first, m_tlast on h4.
//   a word that neither closes a block nor ends the message leaves the input open; the
//   16th word of a block starts 80 rounds of the single round unit plus chain add, and
//   the input stays closed until they end. closing a message pushes the padding and
//   length words one per cycle outside compressions and runs one or two more
//   compressions, then loads the digest into the output buffer.
//   the output buffer holds one digest; if the receiver stalls, the next message is
//   taken in but its digest waits until the buffer has drained.
//   reset (rst, synchronous) reloads the initial chain value, clears the length,
//   the word count and the output buffer valid state.
`include "sha1_hash_engine_defines.svh"

module sha1_hash_engine (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // data_word [31:0], byte_count [34:32], zero [39:35]
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // digest_word [31:0], word_index [34:32], zero [39:35]
  output logic        m_tlast
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_PAD  = 4'b0010,
    S_COMP = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  typedef enum logic [3:0] {
    PH_MARK  = 4'b0001,
    PH_ZERO  = 4'b0010,
    PH_LENLO = 4'b0100,
    PH_DONE  = 4'b1000
  } phase_t;

  state_t               state, state_next;
  phase_t               phase, phase_next;
  logic                 pad_active, pad_next;
  logic [3:0]           count;
  logic [63:0]          bit_length;
  sha1_pkg::core_ctrl_t ctrl;
  logic [31:0]          push_data;
  logic                 core_done;
  logic                 core_idle;
  sha1_pkg::digest_t    digest;
  logic                 load_out;
  logic [2:0]           in_cnt;
  logic [31:0]          in_word;
  sha1_pkg::digest_t    out_buf;
  logic [2:0]           out_idx;
  logic                 out_busy;
  logic                 in_accept;

  assign s_tready  = (state == S_IDLE);
  assign in_accept = s_tvalid && s_tready;
  assign in_cnt    = (s_tdata[34:32] > sha1_pkg::FULL_WORD) ? sha1_pkg::FULL_WORD
                                                          : s_tdata[34:32];
  assign in_word   = s_tdata[31:0] & sha1_pkg::byte_mask(in_cnt);

  always_comb begin
    ctrl       = '0;
    push_data  = in_word;
    state_next = state;
    phase_next = phase;
    pad_next   = pad_active;
    load_out   = 1'b0;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          ctrl.push = 1'b1;
          if (s_tlast) begin
            pad_next = 1'b1;
            if (in_cnt < sha1_pkg::FULL_WORD) begin
              push_data  = in_word | sha1_pkg::pad_marker(in_cnt);
              phase_next = PH_ZERO;
            end else begin
              phase_next = PH_MARK;
            end
          end
          if (count == sha1_pkg::BLOCK_END) state_next = S_COMP;
          else if (s_tlast)                 state_next = S_PAD;
        end
      end
      S_PAD: begin
        ctrl.push = 1'b1;
        case (phase)
          PH_MARK: begin
            push_data  = sha1_pkg::PAD_MARK;
            phase_next = PH_ZERO;
          end
          PH_ZERO: begin
            if (count == sha1_pkg::LEN_SLOT) begin
              push_data  = bit_length[63:32];
              phase_next = PH_LENLO;
            end else begin
              push_data = '0;
            end
          end
          PH_LENLO: begin
            push_data  = bit_length[31:0];
            phase_next = PH_DONE;
          end
          default: begin
            ctrl.push = 1'b0;
            push_data = '0;
          end
        endcase
        if (ctrl.push && count == sha1_pkg::BLOCK_END) state_next = S_COMP;
      end
      S_COMP: begin
        if (core_done) begin
          if (!pad_active)          state_next = S_IDLE;
          else if (phase == PH_DONE) state_next = S_OUT;
          else                       state_next = S_PAD;
        end
      end
      S_OUT: begin
        if (!out_busy) begin
          load_out    = 1'b1;
          ctrl.reinit = 1'b1;
          pad_next    = 1'b0;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
    ctrl.start = ctrl.push && (count == sha1_pkg::BLOCK_END);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      phase      <= PH_DONE;
      pad_active <= 1'b0;
      count      <= '0;
      bit_length <= '0;
      out_busy   <= 1'b0;
      out_idx    <= '0;
    end else begin
      state      <= state_next;
      phase      <= phase_next;
      pad_active <= pad_next;
      if (ctrl.push) begin
        count <= count + 4'd1;
      end
      if (load_out) begin
        bit_length <= '0;
        count      <= '0;
      end else if (in_accept) begin
        bit_length <= bit_length + {58'd0, in_cnt, 3'd0};
      end
      if (load_out) begin
        out_busy <= 1'b1;
        out_idx  <= '0;
      end else if (m_tvalid && m_tready) begin
        if (out_idx == sha1_pkg::DIGEST_END) out_busy <= 1'b0;
        out_idx <= out_idx + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_buf <= digest;
    end
  end

  assign m_tvalid = out_busy;
  assign m_tdata  = {5'd0, out_idx, out_buf[out_idx]};
  assign m_tlast  = (out_idx == sha1_pkg::DIGEST_END);

  sha1_core u_core (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .push_data (push_data),
    .done      (core_done),
    .idle      (core_idle),
    .digest    (digest)
  );

  `SHA1_ASSERT_IMP(a_ready_core_idle, s_tready, core_idle, "input open during compression")
  `SHA1_ASSERT_IMP(a_out_idx_range, out_busy, out_idx <= sha1_pkg::DIGEST_END,
                   "digest index out of range")
  `SHA1_ASSERT_NXT(a_last_closes, in_accept && s_tlast, state != S_IDLE,
                   "final word did not start padding")
  `SHA1_ASSERT_IMP(a_load_when_free, load_out, !out_busy && core_idle,
                   "digest loaded over busy buffer")

endmodule
